// File: sv/tksil_pkg.sv
// Shared types, widths and codes for the top-k scored insertion list.
// Used by the interfaces, the list cell, the top level and the checker.
// No dependencies.
package tksil_pkg;

	// Built depth of the list (1 to 64)
	localparam int DEPTH = 64;

	// Field widths fixed by the item and result formats
	localparam int OP_W    = 2;
	localparam int POS_W   = 24;
	localparam int HEAD_W  = 16;
	localparam int SCORE_W = 32;
	localparam int RANK_W  = 6;
	localparam int CNT_W   = 7;

	// Opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic        [POS_W-1:0]   x;
		logic        [POS_W-1:0]   y;
		logic signed [HEAD_W-1:0]  heading;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ROTATE = 2'd2
	} cell_op_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		cell_op_t op;
		logic     occupied;  // cell index below the fill count
		logic     wrap;      // cell holds the lowest kept entry
	} cell_ctl_t;

	// Clamp a capacity write to 1..DEPTH
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] r;
		if (cap == '0) begin
			r = CNT_W'(1);
		end else if (cap > CNT_W'(DEPTH)) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = cap;
		end
		return r;
	endfunction

endpackage

// File: sv/tksil_ifs.sv
// Channel interfaces of the top-k scored insertion list: items in,
// results out, and the capacity write channel. Depends on tksil_pkg.
interface tksil_item_if;
	import tksil_pkg::*;
	logic                      valid;
	logic                      ready;
	logic        [OP_W-1:0]    opcode;
	logic        [POS_W-1:0]   pos_x;
	logic        [POS_W-1:0]   pos_y;
	logic signed [HEAD_W-1:0]  heading;
	logic signed [SCORE_W-1:0] score;
	modport source (output valid, opcode, pos_x, pos_y, heading, score, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, heading, score, output ready);
endinterface

interface tksil_result_if;
	import tksil_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic                      entry_valid;
	logic        [POS_W-1:0]   out_pos_x;
	logic        [POS_W-1:0]   out_pos_y;
	logic signed [HEAD_W-1:0]  out_heading;
	logic signed [SCORE_W-1:0] out_score;
	logic        [RANK_W-1:0]  rank;
	logic        [CNT_W-1:0]   fill_count;
	logic signed [SCORE_W-1:0] lowest_score;
	logic                      last;
	modport source (output valid, accepted, entry_valid, out_pos_x, out_pos_y, out_heading,
		out_score, rank, fill_count, lowest_score, last, input ready);
	modport sink (input valid, accepted, entry_valid, out_pos_x, out_pos_y, out_heading,
		out_score, rank, fill_count, lowest_score, last, output ready);
endinterface

interface tksil_cfg_if;
	import tksil_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: sv/tksil_cell.sv
// One cell of the sorted list: holds one entry, compares the candidate
// score, and shifts or rotates with its neighbours. Depends on tksil_pkg.
module tksil_cell (
	input  logic               clk,
	input  tksil_pkg::cell_ctl_t ctl,
	input  tksil_pkg::entry_t  cand,
	input  logic               ins_left,
	input  tksil_pkg::entry_t  left_entry,
	input  tksil_pkg::entry_t  right_entry,
	input  tksil_pkg::entry_t  head_entry,
	output tksil_pkg::entry_t  entry_q,
	output logic               ins
);
	import tksil_pkg::*;

	// Candidate belongs at or before this cell
	assign ins = !ctl.occupied || ($signed(cand.score) > $signed(entry_q.score));

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (ins) begin
					entry_q <= ins_left ? left_entry : cand;
				end
			end
			CELL_ROTATE: begin
				entry_q <= ctl.wrap ? head_entry : right_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/top_k_scored_insertion_list.sv
// Top level of the top-k scored insertion list: sequencer, result register
// and a row of tksil_cell. Depends on tksil_pkg, tksil_ifs and tksil_cell.
//
// Usage
//   item_in    : one transfer per command (insert, dump, clear).
//   result_out : results, each held in an output register until taken.
//   cfg        : capacity write, taken only while the block is idle.
// Sequence
//   Insert : capture, parallel compare and shift in all cells, then
//            lowest-score refresh; one result.
//   Clear and the unused opcode: one result.
//   Dump   : the list rotates one cell a cycle past cell 0 while the
//            output is free; cell 0 feeds the result register.
//   Capacity write: the fill is trimmed, then the lowest score refreshed.
// A new item is taken as soon as the previous one is finished, even while
// its last result still waits in the output register; a stalled receiver
// holds a dump, one entry at a time, without losing or repeating any.
// Reset empties the list and sets capacity to the built depth; entry
// storage is not cleared, as only kept entries are ever read.
module top_k_scored_insertion_list (
	input  logic                   clk,
	input  logic                   arst_n,
	tksil_item_if.sink             item_in,
	tksil_result_if.source         result_out,
	tksil_cfg_if.sink              cfg
);
	import tksil_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_TAIL = 4'b0100,
		ST_DUMP = 4'b1000
	} state_t;

	typedef struct packed {
		logic                      accepted;
		logic                      entry_valid;
		entry_t                    entry;
		logic        [RANK_W-1:0]  rank;
		logic        [CNT_W-1:0]   fill_count;
		logic signed [SCORE_W-1:0] lowest_score;
		logic                      last;
	} result_t;

	state_t                    state_q;
	logic        [OP_W-1:0]    op_q;
	entry_t                    cand_q;
	logic        [CNT_W-1:0]   kept_q;
	logic        [CNT_W-1:0]   cap_q;
	logic signed [SCORE_W-1:0] lowest_q;
	logic        [RANK_W-1:0]  cnt_q;
	logic                      emit_q;
	result_t                   res_q;
	result_t                   out_q;
	logic                      out_valid_q;

	entry_t                    cell_entry [DEPTH];
	cell_ctl_t                 cell_ctl   [DEPTH];
	logic        [DEPTH-1:0]   ins;
	logic        [DEPTH-1:0]   ins_left;
	logic        [DEPTH-1:0]   occupied;
	logic        [DEPTH-1:0]   wrap;

	logic                      out_free;
	logic        [CNT_W-1:0]   cap_eff;
	logic                      take_cand;
	logic        [RANK_W-1:0]  ins_rank;
	logic signed [SCORE_W-1:0] tail_score;
	logic                      dump_last;
	logic                      out_load;
	logic                      keep_stats;
	cell_op_t                  cell_op;

	assign out_free = !out_valid_q || result_out.ready;
	assign cap_eff  = eff_cap(cap_q);

	// Accept on room to grow, or when some kept entry is beaten
	assign take_cand = (kept_q < cap_eff) || |(ins & occupied);

	assign dump_last = ({1'b0, cnt_q} + CNT_W'(1)) == kept_q;

	// Dump and the unused opcode report the current fill and lowest score
	assign keep_stats = (op_q == OP_DUMP) || (op_q == OP_UNUSED);

	// Load a new result: single-result commands, the insert tail, each dump entry
	assign out_load = (state_q == ST_EXEC && out_free && op_q != OP_INSERT &&
			!(op_q == OP_DUMP && kept_q != '0)) ||
		(state_q == ST_TAIL && emit_q) ||
		(state_q == ST_DUMP && out_free);

	always_comb begin
		cell_op = CELL_HOLD;
		if (out_free) begin
			if (state_q == ST_EXEC && op_q == OP_INSERT && take_cand) begin
				cell_op = CELL_INSERT;
			end else if (state_q == ST_DUMP) begin
				cell_op = CELL_ROTATE;
			end
		end
	end

	// Row of cells; entry i hands to i+1 on insert, to i-1 on rotate
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occupied[i] = CNT_W'(i) < kept_q;
		assign wrap[i]     = (CNT_W'(i) + CNT_W'(1)) == kept_q;
		assign cell_ctl[i] = '{op: cell_op, occupied: occupied[i], wrap: wrap[i]};
		if (i == 0) begin : g_head
			assign ins_left[i] = 1'b0;
		end else begin : g_body
			assign ins_left[i] = ins[i-1];
		end

		tksil_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.cand       (cand_q),
			.ins_left   (ins_left[i]),
			.left_entry ((i == 0) ? cand_q : cell_entry[(i == 0) ? 0 : i-1]),
			.right_entry((i == DEPTH-1) ? cell_entry[i] : cell_entry[(i == DEPTH-1) ? i : i+1]),
			.head_entry (cell_entry[0]),
			.entry_q    (cell_entry[i]),
			.ins        (ins[i])
		);
	end

	// Insert position: the one cell where the insert flag first rises
	always_comb begin
		ins_rank = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (ins[i] && !ins_left[i]) begin
				ins_rank = ins_rank | RANK_W'(i);
			end
		end
	end

	// Lowest kept score: one-hot select on the tail cell
	always_comb begin
		tail_score = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (wrap[i]) begin
				tail_score = tail_score | cell_entry[i].score;
			end
		end
	end

	assign item_in.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready     = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kept_q      <= '0;
			cap_q       <= CNT_W'(DEPTH);
			lowest_q    <= '0;
			cnt_q       <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold a waiting result until taken, raise on a new one
			out_valid_q <= out_load || (out_valid_q && !result_out.ready);
			case (state_q)
				ST_IDLE: begin
					if (cfg.valid) begin
						// Trim the fill to the new capacity, then refresh lowest
						cap_q  <= cfg.data;
						if (kept_q > eff_cap(cfg.data)) begin
							kept_q <= eff_cap(cfg.data);
						end
						emit_q  <= 1'b0;
						state_q <= ST_TAIL;
					end else if (item_in.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						case (op_q)
							OP_INSERT: begin
								if (take_cand && kept_q < cap_eff) begin
									kept_q <= kept_q + CNT_W'(1);
								end
								emit_q  <= 1'b1;
								state_q <= ST_TAIL;
							end
							OP_DUMP: begin
								if (kept_q == '0) begin
									state_q     <= ST_IDLE;
								end else begin
									cnt_q   <= '0;
									state_q <= ST_DUMP;
								end
							end
							OP_CLEAR: begin
								kept_q      <= '0;
								lowest_q    <= '0;
								state_q     <= ST_IDLE;
							end
							default: begin
								state_q     <= ST_IDLE;
							end
						endcase
					end
				end
				ST_TAIL: begin
					lowest_q <= (kept_q == '0) ? '0 : tail_score;
					state_q <= ST_IDLE;
				end
				ST_DUMP: begin
					if (out_free) begin
						cnt_q       <= cnt_q + RANK_W'(1);
						if (dump_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: captured item, pending insert result and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_in.valid && !cfg.valid) begin
			op_q           <= item_in.opcode;
			cand_q.x       <= item_in.pos_x;
			cand_q.y       <= item_in.pos_y;
			cand_q.heading <= item_in.heading;
			cand_q.score   <= item_in.score;
		end
		if (state_q == ST_EXEC && out_free) begin
			res_q <= '{accepted: take_cand, entry_valid: 1'b0, entry: cand_q,
				rank: take_cand ? ins_rank : '0, fill_count: '0, lowest_score: '0,
				last: 1'b1};
			out_q <= '{accepted: 1'b0, entry_valid: 1'b0, entry: '0, rank: '0,
				fill_count: keep_stats ? kept_q : '0,
				lowest_score: keep_stats ? lowest_q : '0, last: 1'b1};
		end
		if (state_q == ST_TAIL && emit_q) begin
			out_q <= '{accepted: res_q.accepted, entry_valid: res_q.entry_valid,
				entry: res_q.entry, rank: res_q.rank, fill_count: kept_q,
				lowest_score: (kept_q == '0) ? '0 : tail_score, last: res_q.last};
		end
		if (state_q == ST_DUMP && out_free) begin
			out_q <= '{accepted: 1'b0, entry_valid: 1'b1, entry: cell_entry[0],
				rank: cnt_q, fill_count: kept_q, lowest_score: lowest_q,
				last: dump_last};
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.accepted     = out_q.accepted;
	assign result_out.entry_valid  = out_q.entry_valid;
	assign result_out.out_pos_x    = out_q.entry.x;
	assign result_out.out_pos_y    = out_q.entry.y;
	assign result_out.out_heading  = out_q.entry.heading;
	assign result_out.out_score    = out_q.entry.score;
	assign result_out.rank         = out_q.rank;
	assign result_out.fill_count   = out_q.fill_count;
	assign result_out.lowest_score = out_q.lowest_score;
	assign result_out.last         = out_q.last;

endmodule

// File: sv/tksil_checker.sv
// Port-level checks for the top-k scored insertion list, bound to the top
// level. Depends on tksil_pkg and top_k_scored_insertion_list.
module tksil_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               accepted,
	input logic                               entry_valid,
	input logic        [tksil_pkg::RANK_W-1:0]  rank,
	input logic        [tksil_pkg::CNT_W-1:0]   fill_count,
	input logic signed [tksil_pkg::SCORE_W-1:0] lowest_score,
	input logic                               last
);
	import tksil_pkg::*;

	// A stalled result stays valid with rank and last unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(last))
		else $error("result changed while stalled");

	// Fill never exceeds the built depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_count <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// A stored candidate closes its item and carries no dump entry
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> last && !entry_valid && fill_count != '0)
		else $error("bad insert result");

	// A dumped entry ranks inside the fill
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> {1'b0, rank} < fill_count)
		else $error("dump rank outside fill");

	// Empty list reports a zero lowest score
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fill_count == '0 |-> lowest_score == '0 && !entry_valid)
		else $error("empty list result carries data");

endmodule

bind top_k_scored_insertion_list tksil_checker u_tksil_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.accepted    (result_out.accepted),
	.entry_valid (result_out.entry_valid),
	.rank        (result_out.rank),
	.fill_count  (result_out.fill_count),
	.lowest_score(result_out.lowest_score),
	.last        (result_out.last)
);
